@@ hdl/clba_pkg.sv @@
`default_nettype none

package clba_pkg;

    localparam int WORD_BITS  = 64;
    localparam int REQ_W      = 13;
    localparam int COUNT_W    = 7;
    localparam int POS_W      = 6;
    localparam int PAGE_OUT_W = 6;
    localparam int BLOCK_W    = 8;
    localparam int OFFSET_W   = 15;
    localparam int LOG2_W     = 3;

    localparam logic [LOG2_W-1:0]  LINE_LOG2_RESET = 3'd6;
    localparam logic [COUNT_W-1:0] MAX_BLOCKS      = 7'd64;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } t_fit;

    typedef struct packed {
        logic                  first_use_of_page;
        logic [OFFSET_W-1:0]   byte_offset;
        logic [BLOCK_W-1:0]    block_index;
        logic [PAGE_OUT_W-1:0] page_index;
        logic                  granted;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/clba_ram.sv @@
`default_nettype none

module clba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/clba_fit.sv @@
`default_nettype none

module clba_fit
    import clba_pkg::*;
(
    input  wire logic [WORD_BITS-1:0] i_word,
    input  wire logic [WORD_BITS-1:0] i_mask,
    input  wire logic [COUNT_W-1:0]   i_count,
    output t_fit                      o_fit
);

    logic [WORD_BITS-1:0] w_ok;

    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            w_ok[k] = ((i_word & (i_mask << k)) == '0)
                      && ((COUNT_W'(k) + i_count) <= MAX_BLOCKS);
        end
    end

    always_comb begin
        o_fit.found = |w_ok;
        o_fit.pos   = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (w_ok[k]) begin
                o_fit.pos = POS_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/cache_line_bitmap_allocator.sv @@
// Channel   Direction  Word                                   Handshake
// s_axis    in         request_bytes                          tvalid/tready
// m_axis    out        granted, page, block, offset, first    tvalid/tready
// cfg       in         line_size_log2                         i_cfg_valid/o_cfg_ready
//
// A request is taken in S_IDLE; S_LOOK and S_CHECK then walk the bitmap words from the first page
// until a run fits, the fill mark is reached or all words are full; S_DONE passes the result on.
// Words at or above the fill mark read as free, so reset needs no clearing pass.
// A result waits in the output register while the next request is searched.
// The RAM write lands before the next search reads, so no forwarding is needed.
`default_nettype none

module cache_line_bitmap_allocator
    import clba_pkg::*;
#(
    parameter int PAGES          = 64,
    parameter int WORDS_PER_PAGE = 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [12:0] request_bytes
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [0] granted, [6:1] page_index,
                                             // [14:7] block_index, [29:15] byte_offset,
                                             // [30] first_use_of_page
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_data      // [2:0] line_size_log2
);

    localparam int TOTAL = PAGES * WORDS_PER_PAGE;
    localparam int IW    = $clog2(TOTAL + 1);
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int WW    = (WORDS_PER_PAGE > 1) ? $clog2(WORDS_PER_PAGE) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;
    t_result               r_res, n_res;
    logic [IW-1:0]         r_fill, n_fill;
    logic [IW-1:0]         r_idx, n_idx;
    logic [PW-1:0]         r_page, n_page;
    logic [WW-1:0]         r_word, n_word;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [WORD_BITS-1:0]  r_mask, n_mask;
    logic [LOG2_W-1:0]     r_line_log2;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;
    t_fit                  fit;

    logic [REQ_W-1:0]      req_bytes;
    logic [REQ_W-1:0]      line_mask;
    logic [REQ_W:0]        nblocks;
    logic [IW-1:0]         idx_next;
    logic [PW+PAGE_OUT_W-1:0] page_ext;
    logic [WW+1:0]         word_ext;
    logic [BLOCK_W-1:0]    block_zero;
    logic [BLOCK_W-1:0]    block_fit;

    clba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TOTAL)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    clba_fit u_fit (
        .i_word  (ram_rdata),
        .i_mask  (r_mask),
        .i_count (r_count),
        .o_fit   (fit)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};
    assign o_cfg_ready   = 1'b1;

    assign req_bytes  = s_axis_tdata[REQ_W-1:0];
    assign line_mask  = (REQ_W'(1) << r_line_log2) - REQ_W'(1);
    assign nblocks    = {1'b0, req_bytes >> r_line_log2}
                        + (REQ_W+1)'(|(req_bytes & line_mask));
    assign idx_next   = r_idx + IW'(1);
    assign page_ext   = {{PAGE_OUT_W{1'b0}}, r_page};
    assign word_ext   = {2'b00, r_word};
    assign block_zero = {word_ext[1:0], POS_W'(0)};
    assign block_fit  = {word_ext[1:0], fit.pos};

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_res       = r_res;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_page      = r_page;
        n_word      = r_word;
        n_count     = r_count;
        n_mask      = r_mask;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[AW-1:0];
        ram_wdata   = r_mask;
        ram_re      = 1'b0;
        ram_raddr   = r_idx[AW-1:0];

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_idx   = '0;
                    n_page  = '0;
                    n_word  = '0;
                    n_count = nblocks[COUNT_W-1:0];
                    n_mask  = ~({WORD_BITS{1'b1}} << nblocks[COUNT_W-1:0]);
                    if (nblocks == '0 || nblocks > (REQ_W+1)'(MAX_BLOCKS)) begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (r_idx == IW'(TOTAL)) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else if (r_idx >= r_fill) begin
                    ram_we                  = 1'b1;
                    n_fill                  = idx_next;
                    n_res.granted           = 1'b1;
                    n_res.page_index        = page_ext[PAGE_OUT_W-1:0];
                    n_res.block_index       = block_zero;
                    n_res.byte_offset       = {7'b0, block_zero} << r_line_log2;
                    n_res.first_use_of_page = (r_word == '0);
                    n_state                 = S_DONE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (fit.found) begin
                    ram_we                  = 1'b1;
                    ram_wdata               = ram_rdata | (r_mask << fit.pos);
                    n_res.granted           = 1'b1;
                    n_res.page_index        = page_ext[PAGE_OUT_W-1:0];
                    n_res.block_index       = block_fit;
                    n_res.byte_offset       = {7'b0, block_fit} << r_line_log2;
                    n_res.first_use_of_page = 1'b0;
                    n_state                 = S_DONE;
                end else begin
                    n_idx = idx_next;
                    if (r_word == WW'(WORDS_PER_PAGE - 1)) begin
                        n_word = '0;
                        n_page = r_page + PW'(1);
                    end else begin
                        n_word = r_word + WW'(1);
                    end
                    if (idx_next < r_fill) begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_next[AW-1:0];
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_line_log2 <= LINE_LOG2_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fill      <= n_fill;
            r_out       <= n_out;
            r_res       <= n_res;
            r_idx       <= n_idx;
            r_page      <= n_page;
            r_word      <= n_word;
            r_count     <= n_count;
            r_mask      <= n_mask;
            if (i_cfg_valid) begin
                r_line_log2 <= i_cfg_data;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= IW'(TOTAL))
        else $error("fill mark beyond bitmap depth");

    a_check_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_idx < r_fill))
        else $error("bitmap word checked above fill mark");

    a_fresh_grows_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == S_LOOK) |=> (r_fill == $past(r_fill) + IW'(1)))
        else $error("fresh word grant did not advance fill mark");

    a_write_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_state == S_DONE && r_res.granted))
        else $error("bitmap write without a grant");

endmodule

`default_nettype wire

@@ sim/cache_line_bitmap_allocator_tb.sv @@
`default_nettype none

module cache_line_bitmap_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import clba_pkg::*;

    localparam int NUM_PAGES    = 64;
    localparam int REQ_MAX      = 8191;
    localparam int HOLDOFF_LEN  = 400;
    localparam int SETTLE_LEN   = 100;
    localparam int PHASE_ITEMS  = 190;
    localparam int NUM_PHASES   = 10;
    localparam int DIRECTED_PHASES = 3;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} t_rx_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data    = LINE_LOG2_RESET;

    logic [REQ_W-1:0]    req_q[$];
    t_result             grant_q[$];
    logic [WORD_BITS-1:0] line_bitmap[NUM_PAGES];
    logic                page_used[NUM_PAGES];
    logic [LOG2_W-1:0]   line_log2;

    int       errors        = 0;
    logic     req_taken     = 1'b0;
    bit       gaps_on       = 1'b1;
    int       burst_left    = 0;
    int       gap_left      = 0;
    bit       hold_kick     = 1'b0;
    bit       hold_seen     = 1'b0;
    int       hold_left     = 0;
    int       stall_period  = 0;
    int       pattern_pos   = 0;
    t_rx_mode stall_mode    = RX_OPEN;

    cache_line_bitmap_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),     // [12:0] request_bytes
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),     // [0] granted, [6:1] page_index, [14:7] block_index,
                                           // [29:15] byte_offset, [30] first_use_of_page
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)        // [2:0] line_size_log2
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic allocate_first_fit(input logic [REQ_W-1:0] bytes, output t_result res);
        int                   nblk;
        int                   blk;
        logic [WORD_BITS-1:0] run;
        logic [WORD_BITS-1:0] slot;
        bit                   hit;
        res  = '0;
        hit  = 1'b0;
        nblk = (int'(bytes) >> line_log2) +
               (((int'(bytes) & ((1 << line_log2) - 1)) != 0) ? 1 : 0);
        if (nblk == 0 || nblk > WORD_BITS)
            return;
        run = (nblk >= WORD_BITS) ? '1 : ((64'd1 << nblk) - 64'd1);
        for (int p = 0; p < NUM_PAGES && !hit; p++) begin
            for (int k = 0; k + nblk <= WORD_BITS && !hit; k++) begin
                slot = run << k;
                if ((line_bitmap[p] & slot) == '0) begin
                    hit = 1'b1;
                    blk = k;
                    line_bitmap[p] |= slot;
                    res.granted           = 1'b1;
                    res.page_index        = PAGE_OUT_W'(p);
                    res.block_index       = BLOCK_W'(blk);
                    res.byte_offset       = OFFSET_W'(blk << line_log2);
                    res.first_use_of_page = ~page_used[p];
                    page_used[p] = 1'b1;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    function automatic logic [REQ_W-1:0] pick_request(input int sh);
        int r;
        int n;
        int lo;
        int hi;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 8) begin
            lo = (WORD_BITS << sh) + 1;
            return (lo > REQ_MAX) ? REQ_W'($urandom_range(0, REQ_MAX))
                                  : REQ_W'($urandom_range(lo, REQ_MAX));
        end
        if (r < 64)
            n = $urandom_range(1, 4);
        else if (r < 90)
            n = $urandom_range(5, 16);
        else
            n = $urandom_range(17, WORD_BITS);
        lo = ((n - 1) << sh) + 1;
        hi = n << sh;
        if (hi > REQ_MAX)
            hi = REQ_MAX;
        return REQ_W'($urandom_range(lo, hi));
    endfunction

    // sender: bursts with gaps, hold the word until taken
    always @(negedge i_clk) begin: feed
        logic             nv;
        logic [REQ_W-1:0] nd;
        nv = s_axis_tvalid;
        nd = s_axis_tdata[REQ_W-1:0];
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_q.size() > 0) begin
                nd = req_q.pop_front();
                nv = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = gaps_on ? $urandom_range(0, 10) : 0;
                end
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= {{(16-REQ_W){1'b0}}, nd};
    end

    // receiver: own stall pattern, plus one long holdoff on request
    always @(negedge i_clk) begin: drain_side
        logic nr;
        if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = HOLDOFF_LEN;
        end
        if (stall_period == 0) begin
            stall_mode   = t_rx_mode'($urandom_range(0, 3));
            stall_period = $urandom_range(20, 200);
        end else begin
            stall_period--;
        end
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else begin
            case (stall_mode)
                RX_OPEN:   nr = 1'b1;
                RX_COIN:   nr = $urandom_range(0, 1);
                RX_SPARSE: nr = ($urandom_range(0, 3) == 0);
                default:   nr = (pattern_pos % 5) < 3;
            endcase
        end
        pattern_pos++;
        m_axis_tready <= nr;
    end

    always @(posedge i_clk) begin: observe
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            line_log2 = LINE_LOG2_RESET;
            for (int p = 0; p < NUM_PAGES; p++) begin
                line_bitmap[p] = '0;
                page_used[p]   = 1'b0;
            end
        end else begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (i_cfg_valid && o_cfg_ready)
                line_log2 = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                allocate_first_fit(s_axis_tdata[REQ_W-1:0], want);
                grant_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(t_result)-1:0];
                if (grant_q.size() == 0) begin
                    $error("result word with no request pending");
                    errors++;
                end else begin
                    want = grant_q.pop_front();
                    check_field("granted", want.granted, got.granted);
                    check_field("page_index", want.page_index, got.page_index);
                    check_field("block_index", want.block_index, got.block_index);
                    check_field("byte_offset", want.byte_offset, got.byte_offset);
                    check_field("first_use_of_page", want.first_use_of_page,
                                got.first_use_of_page);
                end
            end
        end
    end

    task automatic wait_drained();
        while (req_q.size() != 0 || s_axis_tvalid || grant_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_line_log2(input logic [LOG2_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int              phase_log2[NUM_PHASES] = '{7, 4, 0, 5, 3, 6, 7, 4, 2, 1};
        int              sh;
        int              top;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: zero size, small runs, whole word, run ending at bit 63, too large
        req_q.push_back(REQ_W'(0));
        req_q.push_back(REQ_W'(1));
        req_q.push_back(REQ_W'(65));
        req_q.push_back(REQ_W'(4096));
        req_q.push_back(REQ_W'(3904));
        req_q.push_back(REQ_W'(4097));
        req_q.push_back(REQ_W'(REQ_MAX));
        req_q.push_back(REQ_W'(1));
        req_q.push_back(REQ_W'(64));
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            repeat (SETTLE_LEN) @(posedge i_clk);
            sh = phase_log2[ph];
            write_line_log2(LOG2_W'(sh));
            gaps_on = (ph != 3);
            if (ph < DIRECTED_PHASES) begin
                top = WORD_BITS << sh;
                req_q.push_back(REQ_W'((top > REQ_MAX) ? REQ_MAX : top));
                if (top + 1 <= REQ_MAX)
                    req_q.push_back(REQ_W'(top + 1));
                req_q.push_back(REQ_W'(1));
                req_q.push_back(REQ_W'(0));
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                req_q.push_back(pick_request(sh));
            if (ph == 1)
                hold_kick = ~hold_kick;
            wait_drained();
        end

        repeat (SETTLE_LEN) @(posedge i_clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/clba_pkg.sv
hdl/clba_ram.sv
hdl/clba_fit.sv
hdl/cache_line_bitmap_allocator.sv
sim/cache_line_bitmap_allocator_tb.sv
